/* rtl/rtcs_pkg.sv */
package rtcs_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int JOB_W      = 16;
    localparam int LEN_W      = 8;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 32;
    localparam int DONE_W     = 16;
    localparam int KIND_W     = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = LEN_W + PRIO_W;
    localparam int OUT_DATA_W = JOB_W + 2 * LEN_W + 4 * TIME_W + DONE_W;

    localparam logic CMD_SUBMIT   = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SLICE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_JOB  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SRT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 1'd1;

    localparam logic [CFG_DATA_W-1:0] SLICE_RESET = 8'd1;

    // one row of the ready table
    typedef struct packed {
        logic [JOB_W-1:0]  job;
        logic [LEN_W-1:0]  total;
        logic [LEN_W-1:0]  left;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] order;
    } entry_t;

    typedef struct packed {
        logic   found;
        entry_t entry;
    } pick_t;

    // selection key under the current policy; round robin uses age alone
    function automatic logic [JOB_W-1:0] sel_key(input logic [MODE_W-1:0] mode,
                                                 input entry_t e);
        logic [JOB_W-1:0] k;
        begin
            unique case (mode)
                MODE_JOB:  k = e.job;
                MODE_SRT:  k = JOB_W'(e.left);
                MODE_PRIO: k = JOB_W'(e.prio);
                default:   k = '0;
            endcase
            return k;
        end
    endfunction

endpackage

/* rtl/rtcs_pick.sv */
// Running minimum over the table scan: smaller key wins, equal keys go to the older row.
module rtcs_pick #(
    parameter int IDX_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          load,
    input  rtcs_pkg::entry_t              entry,
    input  logic [IDX_W-1:0]              idx,
    input  logic [rtcs_pkg::MODE_W-1:0]   mode,
    input  logic [rtcs_pkg::TIME_W-1:0]   order_count,
    output rtcs_pkg::pick_t               best,
    output logic [IDX_W-1:0]              best_idx
);

    logic                        found_reg;
    rtcs_pkg::entry_t            entry_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [rtcs_pkg::JOB_W-1:0]  key_reg;
    logic [rtcs_pkg::TIME_W-1:0] age_reg;

    logic [rtcs_pkg::JOB_W-1:0]  key;
    logic [rtcs_pkg::TIME_W-1:0] age;
    logic                        take;

    assign key  = rtcs_pkg::sel_key(mode, entry);
    // age wraps with the order stamp
    assign age  = order_count - entry.order;
    assign take = load && (!found_reg || (key < key_reg) ||
                           ((key == key_reg) && (age > age_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= entry;
            idx_reg   <= idx;
            key_reg   <= key;
            age_reg   <= age;
        end
    end

    assign best.found = found_reg;
    assign best.entry = entry_reg;
    assign best_idx   = idx_reg;

endmodule

/* rtl/ready_table_cpu_scheduler_core.sv */
// Ready table of a CPU scheduler with a virtual clock. A transfer on s_* with tuser 0 submits a
// job (burst and priority in tdata): it takes the lowest free row, gets the next 16-bit job
// number and the current virtual time, and is answered ACCEPT, or REJECT when every row is
// taken. A transfer with tuser 1 dispatches: the whole table is scanned and one job is picked
// (policy 0 lowest job number, 1 least remaining burst, 2 lowest priority value, 3 round robin
// by age), ties going to the oldest row. The job runs its whole remaining burst, or at most
// time_slice units under round robin (0 means no limit), and the clock moves by the run. Each
// command yields exactly one transfer on m_*, the kind in tuser. Rows live in a single-port
// synchronous table memory; valid bits are flops. One command is worked on at a time. A submit
// checks the rows one by one from row 0 until one is free. A dispatch scans the table, reading
// one row per cycle through the memory port, then runs the picked job and, when the job
// finishes, takes two subtract steps for the finish times (turnaround, then waiting).
// A new command is taken while the previous result still waits on m_*. There is no clearing
// pass after reset. Configuration writes are always taken and are meant for idle periods.
module ready_table_cpu_scheduler_core #(
    parameter int TABLE_ENTRIES = rtcs_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rtcs_pkg::IN_DATA_W-1:0]     s_tdata,   // burst_len, prio_level
    input  logic                               s_tuser,   // cmd
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // job_id, slice_run, left_burst, exit_time, turnaround, waiting, idle_total, done_total
    output logic [rtcs_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [rtcs_pkg::KIND_W-1:0]        m_tuser,   // kind
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rtcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_FREE = 3'd1;   // look for the lowest free row
    localparam logic [ST_W-1:0] S_SCAN = 3'd2;   // read every row, keep the best
    localparam logic [ST_W-1:0] S_EXEC = 3'd3;   // run the picked job
    localparam logic [ST_W-1:0] S_TAT  = 3'd4;
    localparam logic [ST_W-1:0] S_WAIT = 3'd5;
    localparam logic [ST_W-1:0] S_OUT  = 3'd6;

    // ---------------------------------------------------------------- control state
    logic [ST_W-1:0]               state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          pv_reg, pv_next;
    logic [IDX_W-1:0]              pidx_reg, pidx_next;
    logic [TABLE_ENTRIES-1:0]      valid_reg, valid_next;
    logic [rtcs_pkg::JOB_W-1:0]    next_job_reg, next_job_next;
    logic [rtcs_pkg::TIME_W-1:0]   order_reg, order_next;
    logic [rtcs_pkg::TIME_W-1:0]   clock_reg, clock_next;
    logic [rtcs_pkg::TIME_W-1:0]   idle_reg, idle_next;
    logic [rtcs_pkg::DONE_W-1:0]   done_reg, done_next;
    logic [rtcs_pkg::MODE_W-1:0]   policy_reg;
    logic [rtcs_pkg::CFG_DATA_W-1:0] slice_reg;
    logic                          m_tvalid_reg;

    // ---------------------------------------------------------------- command and result
    logic                          cmd_reg;
    logic [rtcs_pkg::LEN_W-1:0]    burst_reg;
    logic [rtcs_pkg::PRIO_W-1:0]   prio_reg;
    logic [rtcs_pkg::KIND_W-1:0]   res_kind_reg;
    logic [rtcs_pkg::JOB_W-1:0]    res_job_reg;
    logic [rtcs_pkg::LEN_W-1:0]    res_run_reg;
    logic [rtcs_pkg::LEN_W-1:0]    res_left_reg;
    logic [rtcs_pkg::TIME_W-1:0]   res_exit_reg;
    logic [rtcs_pkg::TIME_W-1:0]   res_tat_reg;
    logic [rtcs_pkg::TIME_W-1:0]   res_wait_reg;
    logic [rtcs_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [rtcs_pkg::KIND_W-1:0]   m_tuser_reg;

    // ---------------------------------------------------------------- table memory
    rtcs_pkg::entry_t              mem [TABLE_ENTRIES];
    rtcs_pkg::entry_t              rd_data_reg;
    rtcs_pkg::entry_t              wr_data;
    logic                          rd_en;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;

    // ---------------------------------------------------------------- pick unit
    rtcs_pkg::pick_t               best;
    logic [IDX_W-1:0]              best_idx;
    logic                          pick_clear;
    logic                          pick_load;

    // ---------------------------------------------------------------- misc
    logic                          in_xfer;
    logic                          out_free;
    logic [IDX_W-1:0]              cur_idx;
    logic [rtcs_pkg::LEN_W-1:0]    rem;
    logic [rtcs_pkg::LEN_W-1:0]    run;
    logic [rtcs_pkg::LEN_W-1:0]    left;
    logic [rtcs_pkg::TIME_W-1:0]   clock_after;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign cur_idx   = cnt_reg[IDX_W-1:0];

    // run length of the picked job; a zero quantum means no limit
    assign rem = best.entry.left;
    assign run = ((policy_reg == rtcs_pkg::MODE_RR) && (slice_reg != '0) && (slice_reg < rem))
                 ? slice_reg : rem;
    assign left        = rem - run;
    assign clock_after = clock_reg + rtcs_pkg::TIME_W'(run);

    // the scan reads only while no write can happen: one command at a time, so no forwarding
    assign rd_en      = (state_reg == S_SCAN) && (cnt_reg != CNT_END);
    assign pick_clear = in_xfer;
    assign pick_load  = (state_reg == S_SCAN) && pv_reg && valid_reg[pidx_reg];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_idx;
        wr_data = best.entry;
        if ((state_reg == S_FREE) && !valid_reg[cur_idx])
        begin
            wr_en           = 1'b1;
            wr_data.job     = next_job_reg;
            wr_data.total   = burst_reg;
            wr_data.left    = burst_reg;
            wr_data.prio    = prio_reg;
            wr_data.arrival = clock_reg;
            wr_data.order   = order_reg;
        end
        else if ((state_reg == S_EXEC) && best.found && (left != '0))
        begin
            // unfinished: back to the tail with the remaining burst
            wr_en         = 1'b1;
            wr_addr       = best_idx;
            wr_data.left  = left;
            wr_data.order = order_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[cur_idx];
        end
    end

    rtcs_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (pick_clear),
        .load        (pick_load),
        .entry       (rd_data_reg),
        .idx         (pidx_reg),
        .mode        (policy_reg),
        .order_count (order_reg),
        .best        (best),
        .best_idx    (best_idx)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        valid_next    = valid_reg;
        next_job_next = next_job_reg;
        order_next    = order_reg;
        clock_next    = clock_reg;
        idle_next     = idle_reg;
        done_next     = done_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next   = '0;
                    state_next = (s_tuser == rtcs_pkg::CMD_DISPATCH) ? S_SCAN : S_FREE;
                end
            end
            S_FREE:
            begin
                if (!valid_reg[cur_idx])
                begin
                    valid_next[cur_idx] = 1'b1;
                    next_job_next       = next_job_reg + 1'b1;
                    order_next          = order_reg + 1'b1;
                    state_next          = S_OUT;
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = cur_idx;
                end
                else if (!pv_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!best.found)
                begin
                    idle_next  = idle_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    clock_next = clock_after;
                    if (left == '0)
                    begin
                        valid_next[best_idx] = 1'b0;
                        done_next            = done_reg + 1'b1;
                        state_next           = S_TAT;
                    end
                    else
                    begin
                        order_next = order_reg + 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_TAT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
            pidx_reg     <= '0;
            valid_reg    <= '0;
            next_job_reg <= rtcs_pkg::JOB_W'(1);
            order_reg    <= '0;
            clock_reg    <= '0;
            idle_reg     <= '0;
            done_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pv_reg       <= pv_next;
            pidx_reg     <= pidx_next;
            valid_reg    <= valid_next;
            next_job_reg <= next_job_next;
            order_reg    <= order_next;
            clock_reg    <= clock_next;
            idle_reg     <= idle_next;
            done_reg     <= done_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= rtcs_pkg::MODE_JOB;
            slice_reg  <= rtcs_pkg::SLICE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rtcs_pkg::REG_POLICY: policy_reg <= cfg_data[rtcs_pkg::MODE_W-1:0];
                rtcs_pkg::REG_SLICE:  slice_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- result payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_reg      <= s_tuser;
                    burst_reg    <= s_tdata[rtcs_pkg::LEN_W-1:0];
                    prio_reg     <= s_tdata[rtcs_pkg::IN_DATA_W-1:rtcs_pkg::LEN_W];
                    res_kind_reg <= rtcs_pkg::KIND_REJECT;
                    res_job_reg  <= '0;
                    res_run_reg  <= '0;
                    res_left_reg <= '0;
                    res_exit_reg <= '0;
                    res_tat_reg  <= '0;
                    res_wait_reg <= '0;
                end
            end
            S_FREE:
            begin
                if (!valid_reg[cur_idx])
                begin
                    res_kind_reg <= rtcs_pkg::KIND_ACCEPT;
                    res_job_reg  <= next_job_reg;
                end
            end
            S_EXEC:
            begin
                if (!best.found)
                begin
                    res_kind_reg <= rtcs_pkg::KIND_IDLE;
                end
                else
                begin
                    res_job_reg  <= best.entry.job;
                    res_run_reg  <= run;
                    res_left_reg <= left;
                    if (left == '0)
                    begin
                        res_kind_reg <= rtcs_pkg::KIND_DONE;
                        res_exit_reg <= clock_after;
                    end
                    else
                    begin
                        res_kind_reg <= rtcs_pkg::KIND_SLICE;
                    end
                end
            end
            S_TAT:
            begin
                res_tat_reg <= res_exit_reg - best.entry.arrival;
            end
            S_WAIT:
            begin
                res_wait_reg <= res_tat_reg - rtcs_pkg::TIME_W'(best.entry.total);
            end
            default: ;
        endcase
    end

    // output register: loaded from the result once the previous transfer has gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            m_tuser_reg <= res_kind_reg;
            m_tdata_reg <= {done_reg, idle_reg, res_wait_reg, res_tat_reg, res_exit_reg,
                            res_left_reg, res_run_reg, res_job_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- checks
    // one command in flight: input closes right after a transfer
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while another is in flight");

    // a dispatch always starts a fresh scan from row zero
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == rtcs_pkg::CMD_DISPATCH)
        |=> (state_reg == S_SCAN && cnt_reg == '0))
        else $error("dispatch did not start a table scan");

    // a finished job leaves nothing of its burst
    a_done_left: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == rtcs_pkg::KIND_DONE) |-> (m_tdata[31:24] == '0))
        else $error("finished job reports a remaining burst");

    // a submit command yields only a submit result (accept or reject)
    a_submit_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free && (cmd_reg == rtcs_pkg::CMD_SUBMIT))
        |-> (res_kind_reg == rtcs_pkg::KIND_ACCEPT || res_kind_reg == rtcs_pkg::KIND_REJECT))
        else $error("submit produced a dispatch result");

endmodule

/* tb/rtcs_checker.sv */
module rtcs_checker #(
    parameter int TABLE_ENTRIES = rtcs_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rtcs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rtcs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [rtcs_pkg::KIND_W-1:0]     m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rtcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtcs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              mismatches,
    output int                              n_done,
    output int                              n_slice,
    output int                              n_reject,
    output int                              n_idle
);
    import rtcs_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [JOB_W-1:0]  job_id;
        logic [LEN_W-1:0]  slice_run;
        logic [LEN_W-1:0]  left_burst;
        logic [TIME_W-1:0] exit_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] idle_total;
        logic [DONE_W-1:0] done_total;
    } sched_result_t;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic [DONE_W-1:0] done_total;
        logic [TIME_W-1:0] idle_total;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] exit_time;
        logic [LEN_W-1:0]  left_burst;
        logic [LEN_W-1:0]  slice_run;
        logic [JOB_W-1:0]  job_id;
    } result_bus_t;

    // shadow ready table
    logic              row_busy    [TABLE_ENTRIES];
    logic [JOB_W-1:0]  row_job     [TABLE_ENTRIES];
    logic [LEN_W-1:0]  row_total   [TABLE_ENTRIES];
    logic [LEN_W-1:0]  row_left    [TABLE_ENTRIES];
    logic [PRIO_W-1:0] row_prio    [TABLE_ENTRIES];
    logic [TIME_W-1:0] row_arrival [TABLE_ENTRIES];
    logic [TIME_W-1:0] row_stamp   [TABLE_ENTRIES];
    logic [JOB_W-1:0]  job_seq;
    logic [TIME_W-1:0] stamp_seq;
    logic [TIME_W-1:0] vclock;
    logic [TIME_W-1:0] idle_cnt;
    logic [DONE_W-1:0] done_cnt;
    logic [MODE_W-1:0] policy;
    logic [7:0]        quantum;
    int                n_results;

    sched_result_t expected_q[$];

    function automatic sched_result_t schedule_step(input logic cmd,
                                                    input logic [LEN_W-1:0] burst,
                                                    input logic [PRIO_W-1:0] prio);
        sched_result_t     r;
        int                row;
        int                i;
        logic [TIME_W-1:0] key;
        logic [TIME_W-1:0] best_key;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] best_age;
        logic [LEN_W-1:0]  run;
        r = '{default: '0};
        row = -1;
        best_key = '0;
        best_age = '0;
        if (cmd == CMD_SUBMIT)
        begin
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (row < 0 && !row_busy[i])
                    row = i;
            end
            if (row < 0)
                r.kind = KIND_REJECT;
            else
            begin
                row_busy[row]    = 1'b1;
                row_job[row]     = job_seq;
                row_total[row]   = burst;
                row_left[row]    = burst;
                row_prio[row]    = prio;
                row_arrival[row] = vclock;
                row_stamp[row]   = stamp_seq;
                stamp_seq        = stamp_seq + 1;
                r.kind           = KIND_ACCEPT;
                r.job_id         = job_seq;
                job_seq          = job_seq + 1;
            end
        end
        else
        begin
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (row_busy[i])
                begin
                    case (policy)
                        MODE_JOB:  key = TIME_W'(row_job[i]);
                        MODE_SRT:  key = TIME_W'(row_left[i]);
                        MODE_PRIO: key = TIME_W'(row_prio[i]);
                        default:   key = '0;
                    endcase
                    age = stamp_seq - row_stamp[i];
                    if (row < 0 || key < best_key || (key == best_key && age > best_age))
                    begin
                        row = i;
                        best_key = key;
                        best_age = age;
                    end
                end
            end
            if (row < 0)
            begin
                idle_cnt = idle_cnt + 1;
                r.kind = KIND_IDLE;
            end
            else
            begin
                run = row_left[row];
                if (policy == MODE_RR && quantum != 0 && quantum < run)
                    run = quantum;
                vclock       = vclock + TIME_W'(run);
                r.job_id     = row_job[row];
                r.slice_run  = run;
                r.left_burst = row_left[row] - run;
                if (r.left_burst == 0)
                begin
                    r.exit_time  = vclock;
                    r.turnaround = vclock - row_arrival[row];
                    r.waiting    = r.turnaround - TIME_W'(row_total[row]);
                    done_cnt     = done_cnt + 1;
                    row_busy[row] = 1'b0;
                    r.kind       = KIND_DONE;
                end
                else
                begin
                    // unfinished: back to the tail
                    row_left[row]  = r.left_burst;
                    row_stamp[row] = stamp_seq;
                    stamp_seq      = stamp_seq + 1;
                    r.kind         = KIND_SLICE;
                end
            end
        end
        r.idle_total = idle_cnt;
        r.done_total = done_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d, %s: expected %0h, got %0h", n_results, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        result_bus_t   got;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                row_busy[i] = 1'b0;
            job_seq   = 1;
            stamp_seq = '0;
            vclock    = '0;
            idle_cnt  = '0;
            done_cnt  = '0;
            policy    = MODE_JOB;
            quantum   = SLICE_RESET;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POLICY)
                    policy = cfg_data[MODE_W-1:0];
                else
                    quantum = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                n_results++;
                got = m_tdata;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: kind %0d with no command waiting",
                                 n_results, m_tuser);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("kind",       32'(want.kind),       32'(m_tuser));
                    check_field("job_id",     32'(want.job_id),     32'(got.job_id));
                    check_field("slice_run",  32'(want.slice_run),  32'(got.slice_run));
                    check_field("left_burst", 32'(want.left_burst), 32'(got.left_burst));
                    check_field("exit_time",  want.exit_time,       got.exit_time);
                    check_field("turnaround", want.turnaround,      got.turnaround);
                    check_field("waiting",    want.waiting,         got.waiting);
                    check_field("idle_total", want.idle_total,      got.idle_total);
                    check_field("done_total", 32'(want.done_total), 32'(got.done_total));
                    case (want.kind)
                        KIND_DONE:   n_done++;
                        KIND_SLICE:  n_slice++;
                        KIND_REJECT: n_reject++;
                        KIND_IDLE:   n_idle++;
                        default:     ;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(schedule_step(s_tuser, s_tdata[LEN_W-1:0],
                                                   s_tdata[IN_DATA_W-1:LEN_W]));
        end
        pending <= expected_q.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the scheduler bench: drives commands, register writes and result stalls, and gives the verdict.
// Prediction and result compare live in rtcs_checker, which watches all three channels.
module testbench;
    import rtcs_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 108;   // commands in each random policy phase

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;    // burst_len, prio_level
    logic                   s_tuser;    // cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   pending;
    int   mismatches;
    int   n_done;
    int   n_slice;
    int   n_reject;
    int   n_idle;
    int   sent;
    logic steady;   // no idling on either side while set

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    ready_table_cpu_scheduler_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtcs_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches),
        .n_done     (n_done),
        .n_slice    (n_slice),
        .n_reject   (n_reject),
        .n_idle     (n_idle)
    );

    // Result side: stall at random with a chance of 28 in 100, never while steady.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 28);

    // Mostly short bursts so jobs finish, slice and tie often; sometimes the full range.
    function automatic logic [LEN_W-1:0] pick_burst();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return LEN_W'($urandom);
            default: return LEN_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Narrow priorities give plenty of ties, which must go to the oldest entry.
    function automatic logic [PRIO_W-1:0] pick_prio();
        if ($urandom_range(1) == 0)
            return PRIO_W'($urandom_range(3));
        return PRIO_W'($urandom);
    endfunction

    // One command transfer, with random idle cycles ahead of it. s_tvalid stays
    // high between back-to-back commands.
    task automatic send_cmd(input logic cmd, input logic [LEN_W-1:0] burst,
                            input logic [PRIO_W-1:0] prio);
        while (!steady && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {prio, burst};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Sender holds off until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [MODE_W-1:0] mode;
        logic [7:0]        quantum;
        int                fill_pct;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_SUBMIT;
        cfg_valid = 1'b0;
        cfg_index = REG_POLICY;
        cfg_data  = '0;
        steady    = 1'b0;
        sent      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset policy (lowest job number):
        // dispatch on an empty table, field extremes, zero burst, full table.
        send_cmd(CMD_DISPATCH, '0, '0);
        send_cmd(CMD_SUBMIT, 8'h00, 8'h00);
        send_cmd(CMD_SUBMIT, 8'hFF, 8'hFF);
        send_cmd(CMD_SUBMIT, 8'hAA, 8'h55);
        send_cmd(CMD_SUBMIT, 8'h55, 8'hAA);
        send_cmd(CMD_DISPATCH, 8'hFF, 8'hFF);   // job 1 runs zero units and finishes
        for (int i = 0; i < 13; i++)
            send_cmd(CMD_SUBMIT, LEN_W'(i + 1), PRIO_W'(i % 3));
        send_cmd(CMD_SUBMIT, 8'h01, 8'h01);     // table full: rejected
        send_cmd(CMD_DISPATCH, '0, '0);
        drain();

        // Random phases. Each one sets the policy and the quantum with the block idle,
        // then mixes submits and dispatches at a phase-specific fill rate so the table
        // swings between empty (idle dispatches) and full (rejects).
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin mode = MODE_JOB;  quantum = 8'd255;                  fill_pct = 50; end
                1:       begin mode = MODE_SRT;  quantum = 8'd0;                    fill_pct = 65; end
                2:       begin mode = MODE_PRIO; quantum = 8'($urandom);            fill_pct = 45; end
                3:       begin mode = MODE_RR;   quantum = 8'd1;                    fill_pct = 40; end
                4:       begin mode = MODE_RR;   quantum = 8'd255;                  fill_pct = 60; end
                5:       begin mode = MODE_RR;   quantum = 8'd0;                    fill_pct = 55; end
                6:       begin mode = MODE_RR;   quantum = 8'($urandom_range(2, 8)); fill_pct = 70; end
                7:       begin mode = MODE_PRIO; quantum = 8'd1;                    fill_pct = 75; end
                8:       begin mode = MODE_SRT;  quantum = 8'd128;                  fill_pct = 35; end
                default: begin mode = MODE_RR;   quantum = 8'($urandom_range(1, 255)); fill_pct = 50; end
            endcase
            // upper bits of a policy write are don't-care; toggle them anyway
            write_reg(REG_POLICY, {6'($urandom), mode});
            write_reg(REG_SLICE, quantum);
            steady <= (ph == 4);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) < fill_pct)
                    send_cmd(CMD_SUBMIT, pick_burst(), pick_prio());
                else
                    send_cmd(CMD_DISPATCH, LEN_W'($urandom), PRIO_W'($urandom));
            end
            drain();
        end
        steady <= 1'b0;

        // leave room for stray results before the summary
        repeat (2 * TABLE_ENTRIES_DEF + 16) @(posedge clk);

        $display("covered %0d commands: directed opening and %0d policy phases", sent, PHASES);
        $display("  %0d jobs finished, %0d quantum slices, %0d full-table rejects, %0d idle",
                 n_done, n_slice, n_reject, n_idle);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
